FILE: rtl/core/imsu_pkg.sv
// ----------------------------------------------------------------------------
// imsu_pkg - shared types and constants for the Ising spin update core
// Widths, request and status codes, controller states and the command and
// status bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package imsu_pkg;

   localparam int NODE_W     = 12;
   localparam int MAX_NODES  = 1 << NODE_W;
   localparam int NCNT_W     = NODE_W + 1;
   localparam int MAX_DEGREE = 6;
   localparam int SLOT_W     = 3;
   localparam int TBL_AW     = NODE_W + SLOT_W;
   localparam int ENTRY_W    = NODE_W + 1;
   localparam int FRAC_W     = 16;
   localparam int NUM_LEVELS = 6;
   localparam int LVL_W      = 3;
   localparam int ACC_W      = 4;
   localparam int TWICE_W    = 16;
   localparam int ENERGY_W   = 15;
   localparam int MAGNET_W   = 14;
   localparam int REQ_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [REQ_W-1:0] {
      REQ_LOAD_EDGE = 3'd0,
      REQ_SET_SPIN  = 3'd1,
      REQ_UPDATE    = 3'd2,
      REQ_COMMIT    = 3'd3,
      REQ_MEASURE   = 3'd4
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODE_COUNT = 3'd0,
      CSR_DEFERRED   = 3'd1,
      CSR_LEVEL_1    = 3'd2,
      CSR_LEVEL_2    = 3'd3,
      CSR_LEVEL_3    = 3'd4,
      CSR_LEVEL_4    = 3'd5,
      CSR_LEVEL_5    = 3'd6,
      CSR_LEVEL_6    = 3'd7
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ_A,
      ST_READ_B,
      ST_EDGE_CHK,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_SET,
      ST_MEAS_INIT,
      ST_NODE_RD,
      ST_NODE_CAP,
      ST_WALK_TBL,
      ST_WALK_SPIN,
      ST_WALK_ACC,
      ST_NODE_END,
      ST_MEAS_DONE,
      ST_COMMIT_RD,
      ST_COMMIT_WR,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_CLEAR,
      DP_ACCEPT,
      DP_READ_B,
      DP_EDGE_CHK,
      DP_EDGE_A,
      DP_EDGE_B,
      DP_SET,
      DP_MEAS_INIT,
      DP_NODE_CAP,
      DP_WALK_SPIN,
      DP_WALK_ACC,
      DP_UPD_END,
      DP_MEAS_END,
      DP_COMMIT_WR
   } dp_act_type;

   typedef enum logic [2:0] {
      RK_NONE,
      RK_CODE,
      RK_SET,
      RK_UPD,
      RK_MEAS
   } res_kind_type;

   typedef struct packed {
      dp_act_type   act;
      res_kind_type stage;
      status_type   code;
      logic         rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic a_out;
      logic b_out;
      logic fits;
      logic cnt_zero;
      logic walk_last;
      logic node_last;
      logic n_zero;
      logic sweep_last;
      logic rsp_free;
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: rtl/core/imsu_ctrl.sv
// ----------------------------------------------------------------------------
// imsu_ctrl - request sequencer
// Steps each request through memory reads, neighbor walk, sweeps and the
// response slot by issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module imsu_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [imsu_pkg::REQ_W-1:0] req_type,
   input  wire imsu_pkg::dp_stat_type     stat,
   output imsu_pkg::dp_cmd_type           cmd
);

   imsu_pkg::state_type             state_ff, state_in;
   logic [imsu_pkg::REQ_W-1:0]      op_ff, op_in;
   logic                            range_err;

   assign range_err = stat.a_out ||
                      ((op_ff == imsu_pkg::REQ_LOAD_EDGE) && stat.b_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= imsu_pkg::ST_CLEAR;
         op_ff    <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         imsu_pkg::ST_CLEAR: begin
            if (stat.sweep_last) state_in = imsu_pkg::ST_IDLE;
         end
         imsu_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in = req_type;
               case (req_type)
                  imsu_pkg::REQ_LOAD_EDGE,
                  imsu_pkg::REQ_SET_SPIN,
                  imsu_pkg::REQ_UPDATE:  state_in = imsu_pkg::ST_READ_A;
                  imsu_pkg::REQ_COMMIT:  state_in = imsu_pkg::ST_COMMIT_RD;
                  imsu_pkg::REQ_MEASURE: state_in = imsu_pkg::ST_MEAS_INIT;
                  default:               state_in = imsu_pkg::ST_RESP;
               endcase
            end
         end
         imsu_pkg::ST_READ_A: begin
            if (range_err)                           state_in = imsu_pkg::ST_RESP;
            else if (op_ff == imsu_pkg::REQ_LOAD_EDGE) state_in = imsu_pkg::ST_READ_B;
            else if (op_ff == imsu_pkg::REQ_SET_SPIN)  state_in = imsu_pkg::ST_SET;
            else                                     state_in = imsu_pkg::ST_NODE_CAP;
         end
         imsu_pkg::ST_READ_B:   state_in = imsu_pkg::ST_EDGE_CHK;
         imsu_pkg::ST_EDGE_CHK: begin
            state_in = stat.fits ? imsu_pkg::ST_EDGE_A : imsu_pkg::ST_RESP;
         end
         imsu_pkg::ST_EDGE_A:   state_in = imsu_pkg::ST_EDGE_B;
         imsu_pkg::ST_EDGE_B:   state_in = imsu_pkg::ST_RESP;
         imsu_pkg::ST_SET:      state_in = imsu_pkg::ST_RESP;
         imsu_pkg::ST_MEAS_INIT: begin
            state_in = stat.n_zero ? imsu_pkg::ST_MEAS_DONE : imsu_pkg::ST_NODE_RD;
         end
         imsu_pkg::ST_NODE_RD:  state_in = imsu_pkg::ST_NODE_CAP;
         imsu_pkg::ST_NODE_CAP: begin
            state_in = stat.cnt_zero ? imsu_pkg::ST_NODE_END : imsu_pkg::ST_WALK_TBL;
         end
         imsu_pkg::ST_WALK_TBL:  state_in = imsu_pkg::ST_WALK_SPIN;
         imsu_pkg::ST_WALK_SPIN: state_in = imsu_pkg::ST_WALK_ACC;
         imsu_pkg::ST_WALK_ACC: begin
            state_in = stat.walk_last ? imsu_pkg::ST_NODE_END : imsu_pkg::ST_WALK_TBL;
         end
         imsu_pkg::ST_NODE_END: begin
            if (op_ff == imsu_pkg::REQ_UPDATE) state_in = imsu_pkg::ST_RESP;
            else if (stat.node_last)           state_in = imsu_pkg::ST_MEAS_DONE;
            else                               state_in = imsu_pkg::ST_NODE_RD;
         end
         imsu_pkg::ST_MEAS_DONE: state_in = imsu_pkg::ST_RESP;
         imsu_pkg::ST_COMMIT_RD: state_in = imsu_pkg::ST_COMMIT_WR;
         imsu_pkg::ST_COMMIT_WR: begin
            state_in = stat.sweep_last ? imsu_pkg::ST_RESP : imsu_pkg::ST_COMMIT_RD;
         end
         imsu_pkg::ST_RESP: begin
            if (stat.rsp_free) state_in = imsu_pkg::ST_IDLE;
         end
         default: state_in = imsu_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready    = 1'b0;
      cmd.act      = imsu_pkg::DP_NOP;
      cmd.stage    = imsu_pkg::RK_NONE;
      cmd.code     = imsu_pkg::STATUS_OK;
      cmd.rsp_load = 1'b0;
      case (state_ff)
         imsu_pkg::ST_CLEAR: cmd.act = imsu_pkg::DP_CLEAR;
         imsu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.act = imsu_pkg::DP_ACCEPT;
               if (!(req_type inside {imsu_pkg::REQ_LOAD_EDGE, imsu_pkg::REQ_SET_SPIN,
                                      imsu_pkg::REQ_UPDATE, imsu_pkg::REQ_COMMIT,
                                      imsu_pkg::REQ_MEASURE})) begin
                  cmd.stage = imsu_pkg::RK_CODE;
               end
            end
         end
         imsu_pkg::ST_READ_A: begin
            if (range_err) begin
               cmd.stage = imsu_pkg::RK_CODE;
               cmd.code  = imsu_pkg::STATUS_RANGE;
            end
         end
         imsu_pkg::ST_READ_B: cmd.act = imsu_pkg::DP_READ_B;
         imsu_pkg::ST_EDGE_CHK: begin
            cmd.act = imsu_pkg::DP_EDGE_CHK;
            if (!stat.fits) begin
               cmd.stage = imsu_pkg::RK_CODE;
               cmd.code  = imsu_pkg::STATUS_FULL;
            end
         end
         imsu_pkg::ST_EDGE_A: cmd.act = imsu_pkg::DP_EDGE_A;
         imsu_pkg::ST_EDGE_B: begin
            cmd.act   = imsu_pkg::DP_EDGE_B;
            cmd.stage = imsu_pkg::RK_CODE;
         end
         imsu_pkg::ST_SET: begin
            cmd.act   = imsu_pkg::DP_SET;
            cmd.stage = imsu_pkg::RK_SET;
         end
         imsu_pkg::ST_MEAS_INIT: cmd.act = imsu_pkg::DP_MEAS_INIT;
         imsu_pkg::ST_NODE_CAP:  cmd.act = imsu_pkg::DP_NODE_CAP;
         imsu_pkg::ST_WALK_SPIN: cmd.act = imsu_pkg::DP_WALK_SPIN;
         imsu_pkg::ST_WALK_ACC:  cmd.act = imsu_pkg::DP_WALK_ACC;
         imsu_pkg::ST_NODE_END: begin
            if (op_ff == imsu_pkg::REQ_UPDATE) begin
               cmd.act   = imsu_pkg::DP_UPD_END;
               cmd.stage = imsu_pkg::RK_UPD;
            end else begin
               cmd.act = imsu_pkg::DP_MEAS_END;
            end
         end
         imsu_pkg::ST_MEAS_DONE: cmd.stage = imsu_pkg::RK_MEAS;
         imsu_pkg::ST_COMMIT_WR: begin
            cmd.act = imsu_pkg::DP_COMMIT_WR;
            if (stat.sweep_last) cmd.stage = imsu_pkg::RK_CODE;
         end
         imsu_pkg::ST_RESP: cmd.rsp_load = stat.rsp_free;
         default: cmd.act = imsu_pkg::DP_NOP;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/core/imsu_datapath.sv
// ----------------------------------------------------------------------------
// imsu_datapath - spin, count and neighbor memories with the walk datapath
// Holds the control registers, request fields, local field accumulator,
// measure sums and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module imsu_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [imsu_pkg::NODE_W-1:0]       req_node_index,
   input  wire logic [imsu_pkg::NODE_W-1:0]       req_other_node,
   input  wire logic                              req_coupling_negative,
   input  wire logic                              req_spin_value,
   input  wire logic [imsu_pkg::FRAC_W-1:0]       req_random_fraction,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [imsu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [imsu_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [imsu_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                   rsp_flipped,
   output logic                                   rsp_spin_now,
   output logic signed [imsu_pkg::ENERGY_W-1:0]   rsp_energy,
   output logic signed [imsu_pkg::MAGNET_W-1:0]   rsp_magnetization,
   input  wire imsu_pkg::dp_cmd_type              cmd,
   output imsu_pkg::dp_stat_type                  stat
);

   localparam int NW = imsu_pkg::NODE_W;
   localparam int SW = imsu_pkg::SLOT_W;

   // configuration
   logic [imsu_pkg::NCNT_W-1:0] node_count_ff;
   logic                        deferred_ff;
   logic [imsu_pkg::FRAC_W-1:0] level_ff [imsu_pkg::NUM_LEVELS];
   logic [imsu_pkg::NCNT_W-1:0] n_act;

   // memories
   logic                         live_mem   [imsu_pkg::MAX_NODES];
   logic                         shadow_mem [imsu_pkg::MAX_NODES];
   logic [SW-1:0]                cnt_mem    [imsu_pkg::MAX_NODES];
   logic [imsu_pkg::ENTRY_W-1:0] tbl_mem    [1 << imsu_pkg::TBL_AW];

   logic                         live_rd_ff, shadow_rd_ff;
   logic [SW-1:0]                cnt_rd_ff;
   logic [imsu_pkg::ENTRY_W-1:0] tbl_rd_ff;

   logic [NW-1:0]                node_raddr;
   logic                         live_we, live_wdata, shadow_we, shadow_wdata;
   logic [NW-1:0]                live_waddr, shadow_waddr, cnt_waddr;
   logic                         cnt_we, tbl_we;
   logic [SW-1:0]                cnt_wdata;
   logic [imsu_pkg::TBL_AW-1:0]  tbl_waddr;
   logic [imsu_pkg::ENTRY_W-1:0] tbl_wdata;

   // working registers
   logic [NW-1:0] a_ff, b_ff, ptr_ff, ptr_in, sweep_ff, sweep_in;
   logic          neg_ff, sv_ff;
   logic [imsu_pkg::FRAC_W-1:0] rnd_ff;
   logic [SW-1:0] slot_ff, slot_in, cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic          spin_a_ff, spin_a_in;
   logic [imsu_pkg::ENTRY_W-1:0] ent_ff, ent_in;
   logic signed [imsu_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [imsu_pkg::MAGNET_W-1:0] magnet_ff, magnet_in;
   logic signed [imsu_pkg::TWICE_W-1:0]  twice_ff, twice_in;

   // staged result and response
   logic [imsu_pkg::STATUS_W-1:0]        res_status_ff, res_status_in;
   logic                                 res_flip_ff, res_flip_in, res_spin_ff, res_spin_in;
   logic signed [imsu_pkg::ENERGY_W-1:0] res_energy_ff, res_energy_in;
   logic signed [imsu_pkg::MAGNET_W-1:0] res_magnet_ff, res_magnet_in;
   logic                                 rsp_valid_ff;

   // decision
   logic signed [imsu_pkg::ACC_W-1:0] k;
   logic [imsu_pkg::LVL_W-1:0]        lvl_idx;
   logic [imsu_pkg::FRAC_W-1:0]       lvl_sel;
   logic                              flip, upd_res, j_ok;
   logic signed [imsu_pkg::ACC_W-1:0] term;

   assign n_act = (node_count_ff > imsu_pkg::NCNT_W'(imsu_pkg::MAX_NODES)) ?
                  imsu_pkg::NCNT_W'(imsu_pkg::MAX_NODES) : node_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= imsu_pkg::NCNT_W'(imsu_pkg::MAX_NODES);
         deferred_ff   <= 1'b0;
         for (int i = 0; i < imsu_pkg::NUM_LEVELS; i++) level_ff[i] <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            imsu_pkg::CSR_NODE_COUNT: node_count_ff <= csr_wdata[imsu_pkg::NCNT_W-1:0];
            imsu_pkg::CSR_DEFERRED:   deferred_ff   <= csr_wdata[0];
            imsu_pkg::CSR_LEVEL_1:    level_ff[0]   <= csr_wdata;
            imsu_pkg::CSR_LEVEL_2:    level_ff[1]   <= csr_wdata;
            imsu_pkg::CSR_LEVEL_3:    level_ff[2]   <= csr_wdata;
            imsu_pkg::CSR_LEVEL_4:    level_ff[3]   <= csr_wdata;
            imsu_pkg::CSR_LEVEL_5:    level_ff[4]   <= csr_wdata;
            imsu_pkg::CSR_LEVEL_6:    level_ff[5]   <= csr_wdata;
            default:                  deferred_ff   <= deferred_ff;
         endcase
      end
   end

   // update decision
   assign k       = spin_a_ff ? acc_ff : -acc_ff;
   assign lvl_idx = imsu_pkg::LVL_W'(k - 4'sd1);

   always_comb begin
      case (lvl_idx)
         3'd0:    lvl_sel = level_ff[0];
         3'd1:    lvl_sel = level_ff[1];
         3'd2:    lvl_sel = level_ff[2];
         3'd3:    lvl_sel = level_ff[3];
         3'd4:    lvl_sel = level_ff[4];
         3'd5:    lvl_sel = level_ff[5];
         default: lvl_sel = '0;
      endcase
   end

   assign flip    = (k <= 4'sd0) || (rnd_ff < lvl_sel);
   assign upd_res = spin_a_ff ^ flip;

   assign j_ok = {1'b0, ent_ff[NW-1:0]} < n_act;
   assign term = !j_ok ? 4'sd0 : ((live_rd_ff ^ ent_ff[NW]) ? 4'sd1 : -4'sd1);

   // memory ports
   always_comb begin
      node_raddr   = ptr_ff;
      live_we      = 1'b0;
      live_waddr   = a_ff;
      live_wdata   = sv_ff;
      shadow_we    = 1'b0;
      shadow_waddr = a_ff;
      shadow_wdata = sv_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = a_ff;
      cnt_wdata    = cnt_a_ff + 1'b1;
      tbl_we       = 1'b0;
      tbl_waddr    = {a_ff, cnt_a_ff};
      tbl_wdata    = {neg_ff, b_ff};
      case (cmd.act)
         imsu_pkg::DP_CLEAR: begin
            live_we      = 1'b1;
            live_waddr   = sweep_ff;
            live_wdata   = 1'b1;
            shadow_we    = 1'b1;
            shadow_waddr = sweep_ff;
            shadow_wdata = 1'b1;
            cnt_we       = 1'b1;
            cnt_waddr    = sweep_ff;
            cnt_wdata    = '0;
         end
         imsu_pkg::DP_READ_B:    node_raddr = b_ff;
         imsu_pkg::DP_WALK_SPIN: node_raddr = tbl_rd_ff[NW-1:0];
         imsu_pkg::DP_EDGE_A: begin
            cnt_we = 1'b1;
            tbl_we = 1'b1;
         end
         imsu_pkg::DP_EDGE_B: begin
            cnt_we    = 1'b1;
            cnt_waddr = b_ff;
            cnt_wdata = cnt_b_ff + 1'b1;
            tbl_we    = 1'b1;
            tbl_waddr = {b_ff, cnt_b_ff};
            tbl_wdata = {neg_ff, a_ff};
         end
         imsu_pkg::DP_SET: begin
            live_we   = 1'b1;
            shadow_we = 1'b1;
         end
         imsu_pkg::DP_UPD_END: begin
            live_we      = !deferred_ff;
            live_wdata   = upd_res;
            shadow_we    = 1'b1;
            shadow_wdata = upd_res;
         end
         imsu_pkg::DP_COMMIT_WR: begin
            live_we    = 1'b1;
            live_waddr = sweep_ff;
            live_wdata = shadow_rd_ff;
         end
         default: node_raddr = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (live_we)   live_mem[live_waddr]     <= live_wdata;
      if (shadow_we) shadow_mem[shadow_waddr] <= shadow_wdata;
      if (cnt_we)    cnt_mem[cnt_waddr]       <= cnt_wdata;
      if (tbl_we)    tbl_mem[tbl_waddr]       <= tbl_wdata;
      live_rd_ff   <= live_mem[node_raddr];
      cnt_rd_ff    <= cnt_mem[node_raddr];
      shadow_rd_ff <= shadow_mem[sweep_ff];
      tbl_rd_ff    <= tbl_mem[{ptr_ff, slot_ff}];
   end

   // working registers
   always_comb begin
      ptr_in        = ptr_ff;
      sweep_in      = sweep_ff;
      slot_in       = slot_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      spin_a_in     = spin_a_ff;
      ent_in        = ent_ff;
      acc_in        = acc_ff;
      magnet_in     = magnet_ff;
      twice_in      = twice_ff;
      case (cmd.act)
         imsu_pkg::DP_CLEAR:     sweep_in = sweep_ff + 1'b1;
         imsu_pkg::DP_COMMIT_WR: sweep_in = sweep_ff + 1'b1;
         imsu_pkg::DP_ACCEPT: begin
            ptr_in   = req_node_index;
            sweep_in = '0;
         end
         imsu_pkg::DP_READ_B:   cnt_a_in = cnt_rd_ff;
         imsu_pkg::DP_EDGE_CHK: cnt_b_in = (a_ff == b_ff) ? cnt_a_ff + 1'b1 : cnt_rd_ff;
         imsu_pkg::DP_MEAS_INIT: begin
            ptr_in    = '0;
            magnet_in = '0;
            twice_in  = '0;
         end
         imsu_pkg::DP_NODE_CAP: begin
            cnt_a_in  = cnt_rd_ff;
            spin_a_in = live_rd_ff;
            slot_in   = '0;
            acc_in    = '0;
         end
         imsu_pkg::DP_WALK_SPIN: ent_in = tbl_rd_ff;
         imsu_pkg::DP_WALK_ACC: begin
            acc_in  = acc_ff + term;
            slot_in = slot_ff + 1'b1;
         end
         imsu_pkg::DP_MEAS_END: begin
            magnet_in = spin_a_ff ? magnet_ff + 14'sd1 : magnet_ff - 14'sd1;
            twice_in  = twice_ff -
                        {{(imsu_pkg::TWICE_W - imsu_pkg::ACC_W){k[imsu_pkg::ACC_W-1]}}, k};
            ptr_in    = ptr_ff + 1'b1;
         end
         default: ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      res_status_in = res_status_ff;
      res_flip_in   = res_flip_ff;
      res_spin_in   = res_spin_ff;
      res_energy_in = res_energy_ff;
      res_magnet_in = res_magnet_ff;
      if (cmd.stage != imsu_pkg::RK_NONE) begin
         res_status_in = imsu_pkg::STATUS_OK;
         res_flip_in   = 1'b0;
         res_spin_in   = 1'b0;
         res_energy_in = '0;
         res_magnet_in = '0;
      end
      case (cmd.stage)
         imsu_pkg::RK_CODE: res_status_in = cmd.code;
         imsu_pkg::RK_SET:  res_spin_in   = sv_ff;
         imsu_pkg::RK_UPD: begin
            res_flip_in = flip;
            res_spin_in = upd_res;
         end
         imsu_pkg::RK_MEAS: begin
            res_energy_in = twice_ff[imsu_pkg::TWICE_W-1:1];
            res_magnet_in = magnet_ff;
         end
         default: res_status_in = res_status_in;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.act == imsu_pkg::DP_ACCEPT) begin
         a_ff   <= req_node_index;
         b_ff   <= req_other_node;
         neg_ff <= req_coupling_negative;
         sv_ff  <= req_spin_value;
         rnd_ff <= req_random_fraction;
      end
      slot_ff       <= slot_in;
      cnt_a_ff      <= cnt_a_in;
      cnt_b_ff      <= cnt_b_in;
      spin_a_ff     <= spin_a_in;
      ent_ff        <= ent_in;
      acc_ff        <= acc_in;
      magnet_ff     <= magnet_in;
      twice_ff      <= twice_in;
      ptr_ff        <= ptr_in;
      res_status_ff <= res_status_in;
      res_flip_ff   <= res_flip_in;
      res_spin_ff   <= res_spin_in;
      res_energy_ff <= res_energy_in;
      res_magnet_ff <= res_magnet_in;
      if (cmd.rsp_load) begin
         rsp_status        <= res_status_ff;
         rsp_flipped       <= res_flip_ff;
         rsp_spin_now      <= res_spin_ff;
         rsp_energy        <= res_energy_ff;
         rsp_magnetization <= res_magnet_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         if (cmd.rsp_load)   rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign stat.a_out      = {1'b0, a_ff} >= n_act;
   assign stat.b_out      = {1'b0, b_ff} >= n_act;
   assign stat.fits       = (a_ff == b_ff) ?
                            (cnt_a_ff <= SW'(imsu_pkg::MAX_DEGREE - 2)) :
                            ((cnt_a_ff < SW'(imsu_pkg::MAX_DEGREE)) &&
                             (cnt_rd_ff < SW'(imsu_pkg::MAX_DEGREE)));
   assign stat.cnt_zero   = (cnt_rd_ff == '0);
   assign stat.walk_last  = (SW'(slot_ff + 1'b1) == cnt_a_ff);
   assign stat.node_last  = (imsu_pkg::NCNT_W'({1'b0, ptr_ff} + 1'b1) == n_act);
   assign stat.n_zero     = (n_act == '0);
   assign stat.sweep_last = &sweep_ff;
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten while held");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> (cnt_wdata <= SW'(imsu_pkg::MAX_DEGREE)))
      else $error("neighbor count above max degree");

   a_field_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.act == imsu_pkg::DP_UPD_END || cmd.act == imsu_pkg::DP_MEAS_END) |->
      (acc_ff <= 4'sd6 && acc_ff >= -4'sd6))
      else $error("local field out of range");

endmodule

`default_nettype wire

FILE: rtl/core/ising_metropolis_spin_update_core.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update_core - Metropolis spin flip engine
// Requests load edges, set spins, update a node, commit shadow spins or
// measure energy and magnetization; one response per request.
//
// Request channel req_*: valid/ready, one request held in work at a time.
// Response channel rsp_*: valid/ready through an output register; a stalled
// response holds and the next request is accepted but waits in its final
// step until the register frees.
// CSR channel csr_*: always ready, write only while no request is pending.
// Steps from accept to response load: set spin writes the node; load edge
// checks room and writes both tables; out-of-range nodes and full tables
// end early, unknown types respond at once; update walks the node's
// neighbors (table read, spin read, accumulate each); measure walks every
// active node; commit reads and writes each of 4096 shadow entries.
// rsp_valid rises the cycle after the load edge, and the next request can
// be accepted in that same cycle. After reset a clearing pass sets all
// 4096 spins to +1 and neighbor counts to zero, with req_ready held low.
// ----------------------------------------------------------------------------
`default_nettype none

module ising_metropolis_spin_update_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [imsu_pkg::REQ_W-1:0]        req_type,
   input  wire logic [imsu_pkg::NODE_W-1:0]       req_node_index,
   input  wire logic [imsu_pkg::NODE_W-1:0]       req_other_node,
   input  wire logic                              req_coupling_negative,
   input  wire logic                              req_spin_value,
   input  wire logic [imsu_pkg::FRAC_W-1:0]       req_random_fraction,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [imsu_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                   rsp_flipped,
   output logic                                   rsp_spin_now,
   output logic signed [imsu_pkg::ENERGY_W-1:0]   rsp_energy,
   output logic signed [imsu_pkg::MAGNET_W-1:0]   rsp_magnetization,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [imsu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [imsu_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   imsu_pkg::dp_cmd_type  cmd;
   imsu_pkg::dp_stat_type stat;

   imsu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   imsu_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_node_index        (req_node_index),
      .req_other_node        (req_other_node),
      .req_coupling_negative (req_coupling_negative),
      .req_spin_value        (req_spin_value),
      .req_random_fraction   (req_random_fraction),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_flipped           (rsp_flipped),
      .rsp_spin_now          (rsp_spin_now),
      .rsp_energy            (rsp_energy),
      .rsp_magnetization     (rsp_magnetization),
      .cmd                   (cmd),
      .stat                  (stat)
   );

endmodule

`default_nettype wire
